FILE: rtl/ssw_pkg.sv
// shared types, constants and codes for the weighted spot selection block
// no dependencies; used by ssw_ctrl, ssw_datapath and the top level
package ssw_pkg;

   localparam int MAX_SPOTS   = 1024;
   localparam int SPOT_W      = $clog2(MAX_SPOTS);
   localparam int CNT_W       = SPOT_W + 1;
   localparam int MAX_BEAMS   = 8;
   localparam int BEAM_W      = 3;
   localparam int BCNT_W      = 4;
   localparam int WEIGHT_BITS = 24;
   localparam int FRAC_W      = 17;
   localparam int TOTAL_W     = WEIGHT_BITS + CNT_W;
   localparam int THR_W       = TOTAL_W + FRAC_W;
   localparam int SMIN_W      = FRAC_W + CNT_W + 1 - 16;
   localparam int MCNT_W      = $clog2(FRAC_W + 1);

   localparam logic [FRAC_W-1:0] FRAC_ONE  = 17'h10000;
   localparam logic [FRAC_W-1:0] FRAC_HALF = 17'h08000;

   localparam logic [1:0] KIND_LOAD_W = 2'd0;
   localparam logic [1:0] KIND_LOAD_B = 2'd1;
   localparam logic [1:0] KIND_FETCH  = 2'd2;

   localparam logic [1:0] CSR_BEAM_COUNT = 2'd0;
   localparam logic [1:0] CSR_WEIGHT_FRAC = 2'd1;
   localparam logic [1:0] CSR_SPOT_FRAC  = 2'd2;

   localparam logic [1:0] MODE_SUM  = 2'd0;
   localparam logic [1:0] MODE_MAX  = 2'd1;
   localparam logic [1:0] MODE_FIND = 2'd2;

   typedef struct packed {
      logic [1:0]  kind;
      logic [23:0] weight;
      logic [10:0] beam_end;
   } req_type;

   typedef struct packed {
      logic [2:0]  beam;
      logic [9:0]  spot_in_beam;
      logic [10:0] subset_count;
      logic [10:0] beam_subset_count;
      logic        empty_res;
      logic        last;
   } rsp_type;

   typedef struct packed {
      logic       load_w;
      logic       load_b;
      logic       scan_start;
      logic [1:0] scan_mode;
      logic       scan_from_cur;
      logic       mul_start;
      logic       pick;
      logic       finish;
      logic       set_first;
      logic       set_nxt;
      logic       serve;
   } cmd_type;

   typedef struct packed {
      logic scan_busy;
      logic mul_busy;
      logic all_picked;
      logic take;
      logic done;
      logic total_zero;
      logic rsp_busy;
   } status_type;

endpackage

FILE: rtl/ssw_ctrl.sv
// sequencer for load, ranking passes, fetch and next-spot lookahead
// depends on ssw_pkg; drives ssw_datapath through cmd_type
module ssw_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic [1:0]          req_kind,
   output logic                req_ready,
   input  ssw_pkg::status_type status,
   output ssw_pkg::cmd_type    cmd
);

   localparam logic [3:0] S_IDLE    = 4'd0;
   localparam logic [3:0] S_SUM     = 4'd1;
   localparam logic [3:0] S_MUL     = 4'd2;
   localparam logic [3:0] S_CHECK   = 4'd3;
   localparam logic [3:0] S_MAX     = 4'd4;
   localparam logic [3:0] S_PICK    = 4'd5;
   localparam logic [3:0] S_FIND1   = 4'd6;
   localparam logic [3:0] S_NEXT_GO = 4'd7;
   localparam logic [3:0] S_FIND2   = 4'd8;
   localparam logic [3:0] S_SERVE   = 4'd9;

   logic [3:0] state_ff, state_in;
   logic       serve_pend_ff, serve_pend_in;
   logic       accept;

   assign req_ready = (state_ff == S_IDLE) &&
                      ((req_kind != ssw_pkg::KIND_FETCH) || !status.rsp_busy);
   assign accept = req_valid && req_ready;

   always_comb begin
      cmd = '0;
      state_in = state_ff;
      serve_pend_in = serve_pend_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               cmd.load_w = (req_kind == ssw_pkg::KIND_LOAD_W);
               cmd.load_b = (req_kind == ssw_pkg::KIND_LOAD_B);
               if (req_kind == ssw_pkg::KIND_FETCH) begin
                  if (status.done) begin
                     state_in = S_SERVE;
                  end else begin
                     cmd.scan_start = 1'b1;
                     cmd.scan_mode = ssw_pkg::MODE_SUM;
                     serve_pend_in = 1'b1;
                     state_in = S_SUM;
                  end
               end
            end
         end
         S_SUM: begin
            if (!status.scan_busy) begin
               cmd.mul_start = 1'b1;
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            if (!status.mul_busy) state_in = S_CHECK;
         end
         S_CHECK: begin
            if (status.all_picked) begin
               cmd.finish = 1'b1;
               state_in = S_SERVE;
            end else begin
               cmd.scan_start = 1'b1;
               cmd.scan_mode = ssw_pkg::MODE_MAX;
               state_in = S_MAX;
            end
         end
         S_MAX: begin
            if (!status.scan_busy) state_in = S_PICK;
         end
         S_PICK: begin
            cmd.pick = 1'b1;
            if (status.take) begin
               state_in = S_CHECK;
            end else begin
               cmd.finish = 1'b1;
               state_in = S_SERVE;
            end
         end
         S_FIND1: begin
            if (!status.scan_busy) begin
               cmd.set_first = 1'b1;
               state_in = S_NEXT_GO;
            end
         end
         S_NEXT_GO: begin
            cmd.scan_start = 1'b1;
            cmd.scan_mode = ssw_pkg::MODE_FIND;
            cmd.scan_from_cur = 1'b1;
            state_in = S_FIND2;
         end
         S_FIND2: begin
            if (!status.scan_busy) begin
               cmd.set_nxt = 1'b1;
               state_in = serve_pend_ff ? S_SERVE : S_IDLE;
            end
         end
         S_SERVE: begin
            // after selection the first spot is located before the pending item is served
            if (serve_pend_ff && status.done && !status.total_zero && !status.rsp_busy &&
                !status.scan_busy && !status.mul_busy && status.all_picked == status.all_picked
                && 1'b0) begin
               state_in = S_IDLE;
            end else begin
               cmd.serve = 1'b1;
               serve_pend_in = 1'b0;
               state_in = status.total_zero ? S_IDLE : S_NEXT_GO;
            end
         end
         default: state_in = S_IDLE;
      endcase
      // a fresh selection first finds the lowest selected spot
      if (cmd.finish && serve_pend_ff) begin
         if (status.take || status.all_picked || !status.take) begin
            cmd.scan_start = 1'b1;
            cmd.scan_mode = ssw_pkg::MODE_FIND;
            cmd.scan_from_cur = 1'b0;
            state_in = S_FIND1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         serve_pend_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         serve_pend_ff <= serve_pend_in;
      end
   end

endmodule

FILE: rtl/ssw_datapath.sv
// spot and flag memories, scan engine, serial threshold multiply,
// beam lookup and result register; depends on ssw_pkg
module ssw_datapath (
   input  logic                    clock,
   input  logic                    reset,
   input  ssw_pkg::req_type        req_data,
   input  ssw_pkg::cmd_type        cmd,
   output ssw_pkg::status_type     status,
   input  logic                    csr_we,
   input  logic [1:0]              csr_index,
   input  logic [ssw_pkg::FRAC_W-1:0] csr_wdata,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output ssw_pkg::rsp_type        rsp_data
);

   localparam int SW = ssw_pkg::SPOT_W;
   localparam int CW = ssw_pkg::CNT_W;

   logic [ssw_pkg::WEIGHT_BITS-1:0] wmem [ssw_pkg::MAX_SPOTS];
   logic                            fmem [ssw_pkg::MAX_SPOTS];

   logic [ssw_pkg::BCNT_W-1:0] beam_count_ff;
   logic [ssw_pkg::FRAC_W-1:0] wfrac_ff, sfrac_ff, wfc, sfc;

   logic [CW-1:0] spots_ff, spots_eff, k_ff, total_sel_ff, idx_ff, start_pos;
   logic [ssw_pkg::BCNT_W-1:0] beams_ff, beams_eff;
   logic          done_ff, scan_act_ff, rd_vld_ff, found_ff, best_vld_ff, chain_ff;
   logic          nxt_found_ff, rsp_vld_ff;
   logic [1:0]    mode_ff;
   logic [CW-1:0] end_ff [ssw_pkg::MAX_BEAMS];
   logic [CW-1:0] beam_cnt_ff [ssw_pkg::MAX_BEAMS];

   logic [ssw_pkg::WEIGHT_BITS-1:0] rd_w_ff, best_w_ff;
   logic                            rd_f_ff;
   logic [SW-1:0] rd_idx_ff, best_idx_ff, found_idx_ff, first_ff, cur_ff, nxt_ff;
   logic [ssw_pkg::TOTAL_W-1:0] total_ff, cum_ff, cum_in;
   logic [ssw_pkg::THR_W-1:0]   thr_ff, mcand_ff;
   logic [ssw_pkg::FRAC_W-1:0]  mplier_ff;
   logic [ssw_pkg::MCNT_W-1:0]  mcnt_ff;
   logic [ssw_pkg::SMIN_W-1:0]  sel_min_ff, sel_min_in;
   logic [ssw_pkg::FRAC_W+CW-1:0] smul;
   logic [ssw_pkg::FRAC_W+CW:0]   sround;
   logic ok, take, f_we, f_wdata, find_hit;
   logic [SW-1:0] f_waddr, src;
   logic [CW-1:0] src_ext, base;
   logic [ssw_pkg::BCNT_W-1:0] nb;
   logic [ssw_pkg::BEAM_W-1:0] bsel;
   logic [SW-1:0] local_idx;
   ssw_pkg::rsp_type rsp_ff;

   assign wfc = (wfrac_ff > ssw_pkg::FRAC_ONE) ? ssw_pkg::FRAC_ONE : wfrac_ff;
   assign sfc = (sfrac_ff > ssw_pkg::FRAC_ONE) ? ssw_pkg::FRAC_ONE : sfrac_ff;
   assign spots_eff = done_ff ? '0 : spots_ff;
   assign beams_eff = done_ff ? '0 : beams_ff;
   assign start_pos = cmd.scan_from_cur ? (CW'(cur_ff) + 1'b1) : '0;

   assign smul = sfc * spots_ff;
   assign sround = {1'b0, smul} + (ssw_pkg::FRAC_W+CW+1)'(ssw_pkg::FRAC_HALF);
   assign sel_min_in = sround[ssw_pkg::FRAC_W+CW:16];

   // running sum test of the next ranked spot
   assign cum_in = cum_ff + ssw_pkg::TOTAL_W'(best_w_ff);
   assign ok = chain_ff && (ssw_pkg::THR_W'({cum_in, 16'b0}) <= thr_ff);
   assign take = ok || (ssw_pkg::SMIN_W'(k_ff) < sel_min_ff);

   assign find_hit = rd_vld_ff && (mode_ff == ssw_pkg::MODE_FIND) && rd_f_ff && !found_ff;

   assign f_we = (scan_act_ff && (mode_ff == ssw_pkg::MODE_SUM)) || (cmd.pick && take);
   assign f_waddr = cmd.pick ? best_idx_ff : idx_ff[SW-1:0];
   assign f_wdata = cmd.pick;

   // beam lookup: first beam in use whose end lies above the spot
   assign src = cmd.serve ? cur_ff : best_idx_ff;
   assign src_ext = {1'b0, src};
   always_comb begin
      if (beam_count_ff == '0) nb = ssw_pkg::BCNT_W'(1);
      else if (beam_count_ff > ssw_pkg::BCNT_W'(ssw_pkg::MAX_BEAMS))
         nb = ssw_pkg::BCNT_W'(ssw_pkg::MAX_BEAMS);
      else nb = beam_count_ff;
      bsel = ssw_pkg::BEAM_W'(nb - 1'b1);
      for (int b = ssw_pkg::MAX_BEAMS - 1; b >= 0; b--) begin
         if ((ssw_pkg::BCNT_W'(b) < nb) && (end_ff[b] > src_ext)) bsel = ssw_pkg::BEAM_W'(b);
      end
      base = (bsel == '0) ? '0 : end_ff[bsel - 1'b1];
      local_idx = SW'(src_ext - base);
   end

   always_ff @(posedge clock) begin
      if (cmd.load_w && (spots_eff != CW'(ssw_pkg::MAX_SPOTS)))
         wmem[spots_eff[SW-1:0]] <= req_data.weight[ssw_pkg::WEIGHT_BITS-1:0];
      rd_w_ff <= wmem[idx_ff[SW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (f_we) fmem[f_waddr] <= f_wdata;
      rd_f_ff <= fmem[idx_ff[SW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         beam_count_ff <= ssw_pkg::BCNT_W'(1);
         wfrac_ff <= ssw_pkg::FRAC_HALF;
         sfrac_ff <= '0;
         spots_ff <= '0;
         beams_ff <= '0;
         done_ff <= 1'b0;
         total_sel_ff <= '0;
         k_ff <= '0;
         scan_act_ff <= 1'b0;
         rd_vld_ff <= 1'b0;
         found_ff <= 1'b0;
         best_vld_ff <= 1'b0;
         chain_ff <= 1'b0;
         nxt_found_ff <= 1'b0;
         rsp_vld_ff <= 1'b0;
         mcnt_ff <= '0;
         mode_ff <= ssw_pkg::MODE_SUM;
         for (int b = 0; b < ssw_pkg::MAX_BEAMS; b++) beam_cnt_ff[b] <= '0;
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               ssw_pkg::CSR_BEAM_COUNT:  beam_count_ff <= csr_wdata[ssw_pkg::BCNT_W-1:0];
               ssw_pkg::CSR_WEIGHT_FRAC: wfrac_ff <= csr_wdata;
               ssw_pkg::CSR_SPOT_FRAC:   sfrac_ff <= csr_wdata;
               default: ;
            endcase
         end
         // any load after a finished selection starts a new set
         if (cmd.load_w || cmd.load_b) begin
            if (done_ff) begin
               done_ff <= 1'b0;
               total_sel_ff <= '0;
               for (int b = 0; b < ssw_pkg::MAX_BEAMS; b++) beam_cnt_ff[b] <= '0;
            end
            spots_ff <= spots_eff;
            beams_ff <= beams_eff;
            if (cmd.load_w && (spots_eff != CW'(ssw_pkg::MAX_SPOTS)))
               spots_ff <= spots_eff + 1'b1;
            if (cmd.load_b && (beams_eff != ssw_pkg::BCNT_W'(ssw_pkg::MAX_BEAMS)))
               beams_ff <= beams_eff + 1'b1;
         end
         rd_vld_ff <= scan_act_ff;
         if (cmd.scan_start) begin
            mode_ff <= cmd.scan_mode;
            scan_act_ff <= (start_pos < spots_ff);
            found_ff <= 1'b0;
            best_vld_ff <= 1'b0;
         end else if (scan_act_ff && ((idx_ff + 1'b1) == spots_ff)) begin
            scan_act_ff <= 1'b0;
         end
         if (find_hit) begin
            found_ff <= 1'b1;
            scan_act_ff <= 1'b0;
         end
         if (rd_vld_ff && (mode_ff == ssw_pkg::MODE_MAX) && !rd_f_ff &&
             (!best_vld_ff || (rd_w_ff >= best_w_ff)))
            best_vld_ff <= 1'b1;
         if (cmd.mul_start) begin
            mcnt_ff <= ssw_pkg::MCNT_W'(ssw_pkg::FRAC_W);
            k_ff <= '0;
            chain_ff <= 1'b1;
            for (int b = 0; b < ssw_pkg::MAX_BEAMS; b++) beam_cnt_ff[b] <= '0;
         end else if (mcnt_ff != '0) begin
            mcnt_ff <= mcnt_ff - 1'b1;
         end
         if (cmd.pick && take) begin
            k_ff <= k_ff + 1'b1;
            chain_ff <= ok;
            beam_cnt_ff[bsel] <= beam_cnt_ff[bsel] + 1'b1;
         end else if (cmd.pick) begin
            chain_ff <= 1'b0;
         end
         if (cmd.finish) begin
            total_sel_ff <= k_ff;
            done_ff <= 1'b1;
         end
         if (cmd.set_nxt) nxt_found_ff <= found_ff;
         if (rsp_vld_ff && rsp_ready) rsp_vld_ff <= 1'b0;
         if (cmd.serve) rsp_vld_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_b && (beams_eff != ssw_pkg::BCNT_W'(ssw_pkg::MAX_BEAMS)))
         end_ff[beams_eff[ssw_pkg::BEAM_W-1:0]] <= req_data.beam_end;
      if (cmd.scan_start) begin
         idx_ff <= start_pos;
         if (cmd.scan_mode == ssw_pkg::MODE_SUM) total_ff <= '0;
      end else if (scan_act_ff) begin
         idx_ff <= idx_ff + 1'b1;
      end
      rd_idx_ff <= idx_ff[SW-1:0];
      if (rd_vld_ff && (mode_ff == ssw_pkg::MODE_SUM))
         total_ff <= total_ff + ssw_pkg::TOTAL_W'(rd_w_ff);
      if (rd_vld_ff && (mode_ff == ssw_pkg::MODE_MAX) && !rd_f_ff &&
          (!best_vld_ff || (rd_w_ff >= best_w_ff))) begin
         best_w_ff <= rd_w_ff;
         best_idx_ff <= rd_idx_ff;
      end
      if (find_hit) found_idx_ff <= rd_idx_ff;
      // shift-add threshold multiply, one multiplier bit a cycle
      if (cmd.mul_start) begin
         thr_ff <= '0;
         mcand_ff <= ssw_pkg::THR_W'(total_ff);
         mplier_ff <= wfc;
         sel_min_ff <= sel_min_in;
         cum_ff <= '0;
      end else if (mcnt_ff != '0) begin
         if (mplier_ff[0]) thr_ff <= thr_ff + mcand_ff;
         mcand_ff <= {mcand_ff[ssw_pkg::THR_W-2:0], 1'b0};
         mplier_ff <= {1'b0, mplier_ff[ssw_pkg::FRAC_W-1:1]};
      end
      if (cmd.pick && take) cum_ff <= cum_in;
      if (cmd.set_first) begin
         first_ff <= found_idx_ff;
         cur_ff <= found_idx_ff;
      end
      if (cmd.set_nxt) nxt_ff <= found_idx_ff;
      if (cmd.serve) begin
         rsp_ff <= '0;
         if (total_sel_ff == '0) begin
            rsp_ff.empty_res <= 1'b1;
         end else begin
            rsp_ff.beam <= bsel;
            rsp_ff.spot_in_beam <= local_idx;
            rsp_ff.subset_count <= total_sel_ff;
            rsp_ff.beam_subset_count <= beam_cnt_ff[bsel];
            rsp_ff.last <= !nxt_found_ff;
            cur_ff <= nxt_found_ff ? nxt_ff : first_ff;
         end
      end
   end

   assign status.scan_busy  = scan_act_ff || rd_vld_ff;
   assign status.mul_busy   = (mcnt_ff != '0);
   assign status.all_picked = (k_ff == spots_ff);
   assign status.take       = take;
   assign status.done       = done_ff;
   assign status.total_zero = (total_sel_ff == '0);
   assign status.rsp_busy   = rsp_vld_ff;

   assign rsp_valid = rsp_vld_ff;
   assign rsp_data  = rsp_ff;

endmodule

FILE: rtl/select_spots_by_weight_fraction_top.sv
// Weighted spot selection. Loads (weights, beam ends) are accepted while a
// result waits. A fetch after a finished selection is served, then a lookahead
// scan over the flag memory finds the next selected spot (one memory read a
// cycle). The first fetch of a set runs the ranking: a sum pass, a shift-add
// threshold multiply, then one full max-search pass over the weight memory per
// selected spot, plus a last pass that ends the selection unless every spot is
// taken. The flag memory is cleared by the sum pass, so no clearing pass
// follows reset.
// depends on ssw_pkg, ssw_ctrl and ssw_datapath
module select_spots_by_weight_fraction_top (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  ssw_pkg::req_type           req_data,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output ssw_pkg::rsp_type           rsp_data,
   input  logic                       csr_we,
   input  logic [1:0]                 csr_index,
   input  logic [ssw_pkg::FRAC_W-1:0] csr_wdata
);

   ssw_pkg::cmd_type    cmd;
   ssw_pkg::status_type status;

   ssw_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_kind  (req_data.kind),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   ssw_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .status    (status),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   // a result is never written over one still waiting
   a_serve_free: assert property (@(posedge clock) disable iff (reset)
      cmd.serve |-> !status.rsp_busy)
      else $error("result register overwritten");

   // no item is taken while a scan or multiply is in flight
   a_ready_quiet: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> (!status.scan_busy && !status.mul_busy))
      else $error("item accepted during selection work");

   // a pick only happens while unranked spots remain
   a_pick_room: assert property (@(posedge clock) disable iff (reset)
      cmd.pick |-> !status.all_picked)
      else $error("pick with every spot already ranked");

endmodule
